>>> hw/rtl/lad_pkg.sv
// Package: shared constants, types and command struct for the linear array deque.
`default_nettype none
package lad_pkg;

   localparam int DEPTH    = 16;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int MARK_W   = ADDR_W + 1;
   localparam int WORD_W   = 32;
   localparam int OCC_W    = 5;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NO_FRONT = 2'd1,
      ST_NO_REAR  = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_EXEC,
      CTL_RESP
   } ctl_state_type;

   typedef struct packed {
      logic load;   // capture the request word
      logic exec;   // perform the operation, register the response
   } cmd_type;

endpackage
`default_nettype wire

>>> hw/rtl/lad_if.sv
// Interfaces: request and response channels of the linear array deque.
`default_nettype none
interface lad_req_if import lad_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               operation;
   logic signed [WORD_W-1:0] push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface lad_rsp_if import lad_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] pop_value;
   logic [1:0]               status;
   logic [OCC_W-1:0]         occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);
endinterface
`default_nettype wire

>>> hw/rtl/linear_array_deque_unit.sv
// Top level: double-ended queue in a linear, non-wrapping word store.
`default_nettype none
// Double-ended queue over a linear store of DEPTH (16) signed 32-bit words.
// Each request word carries one operation (push front, push rear, pop front,
// pop rear) and yields exactly one response word with the popped value, a
// status and the occupancy after the operation. The store does not wrap:
// the front mark starts at -1, so a push at the front is refused until pops
// at the front have freed slots, and room freed at one end is never usable
// from the other. Refused operations leave the queue unchanged and return
// value 0. One word is handled at a time: capture, execute (one memory
// access plus the registered read), then the response is held until taken.
// Slot contents come up undefined after reset; only written slots are ever
// read.
module linear_array_deque_unit import lad_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   lad_req_if.sink    req_ch,
   lad_rsp_if.source  rsp_ch
);

   cmd_type cmd;

   lad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   lad_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .operation  (req_ch.operation),
      .push_value (req_ch.push_value),
      .pop_value  (rsp_ch.pop_value),
      .status     (rsp_ch.status),
      .occupancy  (rsp_ch.occupancy)
   );

endmodule
`default_nettype wire

>>> hw/rtl/lad_ctrl.sv
// Controller: sequences capture, execute and response for one word at a time.
`default_nettype none
module lad_ctrl import lad_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output cmd_type      cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_EXEC;
         end
         CTL_EXEC: begin
            state_in = CTL_RESP;
         end
         CTL_RESP: begin
            if (rsp_ready) state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         CTL_EXEC: begin
            cmd.exec = 1'b1;
         end
         CTL_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/lad_dpath.sv
// Datapath: slot memory, front/rear marks and response registers.
`default_nettype none
module lad_dpath import lad_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   input  wire logic [1:0]               operation,
   input  wire logic signed [WORD_W-1:0] push_value,
   output logic signed [WORD_W-1:0]      pop_value,
   output logic [1:0]                    status,
   output logic [OCC_W-1:0]              occupancy
);

   localparam logic signed [MARK_W-1:0] LAST_MARK = MARK_W'(DEPTH - 1);
   localparam logic signed [MARK_W-1:0] ONE_MARK  = MARK_W'(1);

   op_type                     op_ff;
   logic signed [WORD_W-1:0]   word_ff;
   logic signed [MARK_W-1:0]   front_ff, front_in;
   logic signed [MARK_W-1:0]   rear_ff, rear_in;
   logic signed [WORD_W-1:0]   pop_value_ff;
   status_type                 status_ff, status_in;
   logic [OCC_W-1:0]           occupancy_ff;
   logic [WORD_W-1:0]          slots [DEPTH];

   logic                       empty;
   logic                       wr_en;
   logic                       rd_en;
   logic [MARK_W-1:0]          addr_mark;
   logic [ADDR_W-1:0]          addr;
   logic [MARK_W-1:0]          diff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(operation);
         word_ff <= push_value;
      end
   end

   assign empty = (front_ff == rear_ff);

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      status_in = ST_DONE;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      addr_mark = front_ff;
      case (op_ff)
         OP_PUSH_FRONT: begin
            // front mark at -1: nothing below slot 0
            if (front_ff[MARK_W-1]) begin
               status_in = ST_NO_FRONT;
            end else begin
               wr_en     = 1'b1;
               addr_mark = front_ff;
               front_in  = front_ff - ONE_MARK;
            end
         end
         OP_PUSH_REAR: begin
            if (rear_ff == LAST_MARK) begin
               status_in = ST_NO_REAR;
            end else begin
               wr_en     = 1'b1;
               addr_mark = rear_ff + ONE_MARK;
               rear_in   = rear_ff + ONE_MARK;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en     = 1'b1;
               addr_mark = front_ff + ONE_MARK;
               front_in  = front_ff + ONE_MARK;
            end
         end
         OP_POP_REAR: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               rd_en     = 1'b1;
               addr_mark = rear_ff;
               rear_in   = rear_ff - ONE_MARK;
            end
         end
         default: begin
            status_in = ST_EMPTY;
         end
      endcase
   end

   assign addr = addr_mark[ADDR_W-1:0];
   assign diff = rear_in - front_in;

   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) begin
         slots[addr] <= word_ff;
      end
   end

   // registered read, forced to zero when nothing is popped
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (rd_en) begin
            pop_value_ff <= slots[addr];
         end else begin
            pop_value_ff <= '0;
         end
         status_ff    <= status_in;
         occupancy_ff <= OCC_W'(diff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '1;
         rear_ff  <= '1;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
      end
   end

   assign pop_value = pop_value_ff;
   assign status    = status_ff;
   assign occupancy = occupancy_ff;

endmodule
`default_nettype wire
